// File: rtl/fixed_block_free_list_allocator_assert.svh
// Assertion macros for the block free list allocator.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH

`ifndef SYNTH
`define FBFL_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("fbfl assertion failed");
`define FBFL_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("fbfl assertion failed");
`else
`define FBFL_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define FBFL_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

// File: rtl/fbfl_pkg.sv
package fbfl_pkg;

    localparam int NUM_BLOCKS_DEF = 1024;
    localparam int CNT_W          = 11;
    localparam int IDX_W          = 10;
    localparam int STAT_W         = 2;

    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [STAT_W-1:0] stat_t;

    localparam logic  CMD_ALLOC = 1'b0;
    localparam logic  CMD_FREE  = 1'b1;

    localparam stat_t ST_OK  = 2'd0;
    localparam stat_t ST_OOM = 2'd1;
    localparam stat_t ST_BAD = 2'd2;

    localparam cnt_t  RESET_BLOCK_COUNT = 11'd1024;

    // clamp the programmed block count to 1 .. nb
    function automatic cnt_t clamp_count(cnt_t bc, int nb);
        cnt_t r;
        if (bc == '0)
            r = cnt_t'(1);
        else if (32'(bc) > nb)
            r = cnt_t'(nb);
        else
            r = bc;
        return r;
    endfunction

endpackage

// File: rtl/fbfl_ram.sv
module fbfl_ram
    import fbfl_pkg::*;
#(
    parameter int WIDTH = CNT_W,
    parameter int DEPTH = NUM_BLOCKS_DEF
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/fixed_block_free_list_allocator.sv
// Fixed-size block pool allocator. Each request allocates (cmd 0) or frees
// (cmd 1) one block index; free blocks are threaded through a link memory
// as a singly linked list that is built lazily, one block per allocate.
// At accept, an allocate issues the link memory read at the list head (and
// the lazy link write); completion updates the head and counters, writes a
// freed block's link and loads the result register; it waits while an
// earlier result is still held by out_ready low. Writing block_count
// (clamped to 1 .. NUM_BLOCKS) makes all blocks free again; the write is
// taken only while no request is in flight, and a pending write holds off
// new requests. No clearing pass after reset.
`include "fixed_block_free_list_allocator_assert.svh"

module fixed_block_free_list_allocator
    import fbfl_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  idx_t        free_index,
    output logic        out_valid,
    input  logic        out_ready,
    output idx_t        block_index,
    output stat_t       status,
    output cnt_t        free_count,
    output logic        is_full,
    output logic        is_empty,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  cnt_t        block_count
);

    localparam int AW = $clog2(NUM_BLOCKS);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DONE = 1'b1;

    logic  state_reg, state_next;
    logic  cmd_reg;
    idx_t  fidx_reg;
    cnt_t  bcount_reg;
    cnt_t  head_reg, head_next;
    cnt_t  total_reg, total_next;
    cnt_t  init_reg, init_next;
    logic  out_valid_reg, out_valid_next;
    idx_t  out_index_reg;
    stat_t out_status_reg;
    cnt_t  out_count_reg;
    logic  out_full_reg;
    logic  out_empty_reg;

    cnt_t  cnt;
    logic  pending;
    logic  alloc_ok;
    logic  free_ok;
    logic  in_fire;
    logic  cfg_fire;
    logic  done_fire;
    logic  lazy_wr;
    logic  free_wr;
    logic  rd_en;
    cnt_t  rd_data;
    cnt_t  head_link;
    idx_t  got;
    stat_t stat_c;

    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    cnt_t          ram_wr_data;

    assign cnt       = clamp_count(bcount_reg, NUM_BLOCKS);
    assign pending   = init_reg < cnt;
    assign alloc_ok  = (total_reg != '0) && (head_reg < cnt);
    assign free_ok   = (cnt_t'(fidx_reg) < cnt) && (total_reg < cnt);

    // config write wins over a new request
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign done_fire = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // lazy link at accept; state is stable until the request completes
    assign lazy_wr = in_fire && (cmd == CMD_ALLOC) && alloc_ok && pending;
    assign rd_en   = in_fire && (cmd == CMD_ALLOC);
    assign free_wr = done_fire && (cmd_reg == CMD_FREE) && free_ok;

    assign ram_wr_en   = lazy_wr || free_wr;
    assign ram_wr_addr = lazy_wr ? AW'(init_reg) : AW'(fidx_reg);
    assign ram_wr_data = lazy_wr ? cnt_t'(init_reg + 1'b1) : head_reg;

    fbfl_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_BLOCKS)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (rd_en),
        .rd_addr (AW'(head_reg)),
        .rd_data (rd_data)
    );

    // forward the link written by the lazy step
    assign head_link = (pending && (head_reg == init_reg)) ? cnt_t'(init_reg + 1'b1)
                                                            : rd_data;

    always_comb
    begin
        head_next  = head_reg;
        total_next = total_reg;
        init_next  = init_reg;
        got        = '0;
        stat_c     = ST_OK;
        if (cmd_reg == CMD_ALLOC)
        begin
            if (alloc_ok)
            begin
                got        = idx_t'(head_reg);
                head_next  = head_link;
                total_next = total_reg - 1'b1;
                if (pending)
                begin
                    init_next = init_reg + 1'b1;
                end
            end
            else
            begin
                stat_c = ST_OOM;
            end
        end
        else
        begin
            if (free_ok)
            begin
                head_next  = cnt_t'(fidx_reg);
                total_next = total_reg + 1'b1;
            end
            else
            begin
                stat_c = ST_BAD;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (done_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (done_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            bcount_reg    <= RESET_BLOCK_COUNT;
            head_reg      <= '0;
            init_reg      <= '0;
            total_reg     <= clamp_count(RESET_BLOCK_COUNT, NUM_BLOCKS);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_fire)
            begin
                bcount_reg <= block_count;
                head_reg   <= '0;
                init_reg   <= '0;
                total_reg  <= clamp_count(block_count, NUM_BLOCKS);
            end
            else if (done_fire)
            begin
                head_reg  <= head_next;
                init_reg  <= init_next;
                total_reg <= total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg  <= cmd;
            fidx_reg <= free_index;
        end
        if (done_fire)
        begin
            out_index_reg  <= got;
            out_status_reg <= stat_c;
            out_count_reg  <= total_next;
            out_full_reg   <= (total_next == '0);
            out_empty_reg  <= (total_next == cnt);
        end
    end

    assign out_valid   = out_valid_reg;
    assign block_index = out_index_reg;
    assign status      = out_status_reg;
    assign free_count  = out_count_reg;
    assign is_full     = out_full_reg;
    assign is_empty    = out_empty_reg;

    `FBFL_ASSERT_IMPL(a_total_in_range, clk, rst_n, 1'b1, total_reg <= cnt)
    `FBFL_ASSERT_IMPL(a_init_in_range, clk, rst_n, 1'b1, init_reg <= cnt)
    `FBFL_ASSERT_IMPL(a_full_empty_excl, clk, rst_n, out_valid_reg,
        !(out_full_reg && out_empty_reg))
    `FBFL_ASSERT_NEXT(a_alloc_dec, clk, rst_n,
        done_fire && !cfg_fire && (cmd_reg == CMD_ALLOC) && alloc_ok,
        (total_reg == $past(total_reg) - 1'b1) && (status == ST_OK))
    `FBFL_ASSERT_IMPL(a_lazy_only_alloc, clk, rst_n, ram_wr_en,
        !(lazy_wr && free_wr))

endmodule
